[sv/pvs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the polynomial value and slope block.
// Depends on nothing; every other file of the block uses it.

package pvs_pkg;

	// Field widths (fixed by the data formats).
	localparam int W_Q48      = 48;
	localparam int W_POINT    = 32;
	localparam int W_PROD     = 80;
	localparam int W_WIDE     = 81;
	localparam int MUL_SPLIT  = 24;
	localparam int NUM_COEFFS = 6;
	localparam int W_TERMS    = 3;
	localparam int W_REG_IDX  = 3;

	// Register indexes of the configuration port.
	localparam logic [W_REG_IDX-1:0] REG_TERM_COUNT = 3'd0;
	localparam logic [W_REG_IDX-1:0] REG_COEFF_0    = 3'd1;

	// Saturation limits of signed Q16.32.
	localparam logic signed [W_Q48-1:0] Q48_MAX = {1'b0, {(W_Q48-1){1'b1}}};
	localparam logic signed [W_Q48-1:0] Q48_MIN = {1'b1, {(W_Q48-1){1'b0}}};

	// Reset values of the configuration registers.
	localparam logic [W_TERMS-1:0] TERM_COUNT_RESET = 3'd2;
	localparam logic signed [W_Q48-1:0] COEFF_RESET [NUM_COEFFS] = '{
		48'sd0, 48'sd4294967296, 48'sd0, 48'sd0, 48'sd0, 48'sd0
	};

	typedef logic signed [W_Q48-1:0] pvs_q48_t;

	// Horner state that travels down the pipeline with each point.
	typedef struct packed {
		logic signed [W_Q48-1:0]   val;
		logic signed [W_Q48-1:0]   slp;
		logic                      vsat;
		logic                      ssat;
		logic signed [W_POINT-1:0] x;
	} pvs_data_t;

	// One pipeline stage boundary: valid bit plus the Horner state.
	typedef struct packed {
		logic      valid;
		pvs_data_t data;
	} pvs_beat_t;

	// Coefficient terms prepared for the pipeline. Terms beyond the term count read as zero.
	typedef struct packed {
		pvs_q48_t [NUM_COEFFS-1:0] val_term;
		pvs_q48_t [NUM_COEFFS-1:0] slp_term;
		logic                      slp_sat;
	} pvs_coef_t;

	// A value clipped to Q16.32 with its clip flag.
	typedef struct packed {
		logic                    sat;
		logic signed [W_Q48-1:0] val;
	} pvs_clip_t;

	// Clip a wide signed value to the 48-bit range.
	function automatic pvs_clip_t pvs_clip48(input logic signed [W_WIDE-1:0] v);
		pvs_clip_t r;
		r.sat = (v[W_WIDE-1:W_Q48-1] != '0) && (v[W_WIDE-1:W_Q48-1] != '1);
		if (!r.sat) begin
			r.val = v[W_Q48-1:0];
		end else if (v[W_WIDE-1]) begin
			r.val = Q48_MIN;
		end else begin
			r.val = Q48_MAX;
		end
		return r;
	endfunction

	// Join the two partial products and round on frac bits, ties away from zero.
	function automatic logic signed [W_PROD-1:0] pvs_round(
		input logic signed [W_Q48-MUL_SPLIT+W_POINT-1:0] hi,
		input logic signed [MUL_SPLIT+W_POINT:0]         lo,
		input int unsigned                               frac
	);
		logic signed [W_PROD-1:0] p;
		logic [W_PROD-1:0]        half;
		logic                     adj;
		p    = $signed({hi, {MUL_SPLIT{1'b0}}}) + W_PROD'(lo);
		half = (W_PROD'(1) << frac) >> 1;
		adj  = (frac != 0) && p[W_PROD-1];
		return (p + $signed(half) - $signed({{(W_PROD-1){1'b0}}, adj})) >>> frac;
	endfunction

	// Clip the rounded product, add the next term and clip again.
	function automatic pvs_clip_t pvs_accumulate(
		input logic signed [W_PROD-1:0] r,
		input logic signed [W_Q48-1:0]  c
	);
		pvs_clip_t             first;
		pvs_clip_t             second;
		logic signed [W_Q48:0] sum;
		first  = pvs_clip48(W_WIDE'(r));
		sum    = W_Q48'(first.val) + (W_Q48+1)'(c);
		sum    = (W_Q48+1)'(first.val) + (W_Q48+1)'(c);
		second = pvs_clip48(W_WIDE'(sum));
		second.sat = second.sat | first.sat;
		return second;
	endfunction

endpackage

[sv/pvs_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the polynomial value and slope block.
// Depends on pvs_pkg for field widths.

// Input channel: one abscissa per transaction.
interface pvs_point_if;
	logic                               valid;
	logic                               ready;
	logic signed [pvs_pkg::W_POINT-1:0] point;
	modport source (output valid, output point, input ready);
	modport sink (input valid, input point, output ready);
endinterface

// Output channel: value and slope with their clip flags.
interface pvs_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [pvs_pkg::W_Q48-1:0] value;
	logic signed [pvs_pkg::W_Q48-1:0] slope;
	logic                             value_saturated;
	logic                             slope_saturated;
	modport source (output valid, output value, output slope, output value_saturated,
		output slope_saturated, input ready);
	modport sink (input valid, input value, input slope, input value_saturated,
		input slope_saturated, output ready);
endinterface

// Configuration write channel.
interface pvs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pvs_pkg::W_REG_IDX-1:0]     index;
	logic [pvs_pkg::W_Q48-1:0]         data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/pvs_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers and the coefficient terms derived from them.
// Depends on pvs_pkg and pvs_cfg_if.

module pvs_cfg #(
	parameter int MAX_TERMS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	pvs_cfg_if.sink            cfg,
	output pvs_pkg::pvs_coef_t coef
);

	logic [pvs_pkg::W_TERMS-1:0]         term_count_q;
	logic signed [pvs_pkg::W_Q48-1:0]    coeff_q [pvs_pkg::NUM_COEFFS];
	logic signed [pvs_pkg::W_Q48-1:0]    vt_d [pvs_pkg::NUM_COEFFS];
	logic signed [pvs_pkg::W_Q48-1:0]    st_d [pvs_pkg::NUM_COEFFS];
	logic [pvs_pkg::NUM_COEFFS-1:0]      sat_d;
	pvs_pkg::pvs_coef_t                  coef_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= pvs_pkg::TERM_COUNT_RESET;
			for (int i = 0; i < pvs_pkg::NUM_COEFFS; i++) begin
				coeff_q[i] <= pvs_pkg::COEFF_RESET[i];
			end
		end else if (cfg.valid) begin
			if (cfg.index == pvs_pkg::REG_TERM_COUNT) begin
				term_count_q <= cfg.data[pvs_pkg::W_TERMS-1:0];
			end
			for (int i = 0; i < pvs_pkg::NUM_COEFFS; i++) begin
				if (cfg.index == pvs_pkg::W_REG_IDX'(pvs_pkg::REG_COEFF_0 + i)) begin
					coeff_q[i] <= $signed(cfg.data);
				end
			end
		end
	end

	// Per-term preparation: mask terms beyond the term count, and form k * coeff_k
	// clipped for the slope.
	for (genvar k = 0; k < pvs_pkg::NUM_COEFFS; k++) begin : g_term
		logic                                live;
		logic signed [pvs_pkg::W_Q48+3:0]    kc;
		pvs_pkg::pvs_clip_t                  kclip;

		assign live  = (k < MAX_TERMS) && (pvs_pkg::W_TERMS'(k) < term_count_q);
		assign kc    = coeff_q[k] * $signed({1'b0, pvs_pkg::W_TERMS'(k)});
		assign kclip = pvs_pkg::pvs_clip48(pvs_pkg::W_WIDE'(kc));

		assign vt_d[k]  = live ? coeff_q[k] : '0;
		assign st_d[k]  = (live && (k != 0)) ? kclip.val : '0;
		assign sat_d[k] = live && (k != 0) && kclip.sat;
	end

	// Register the prepared terms so the pipeline sees a short path.
	always_ff @(posedge clk) begin
		for (int i = 0; i < pvs_pkg::NUM_COEFFS; i++) begin
			coef_q.val_term[i] <= vt_d[i];
			coef_q.slp_term[i] <= st_d[i];
		end
		coef_q.slp_sat <= |sat_d;
	end

	assign coef = coef_q;

endmodule

[sv/pvs_step.sv]
`timescale 1ns / 1ps
// One Horner step for value and slope: multiply, round, then add the next term.
// Three register stages with per-stage valid and stall. Depends on pvs_pkg.

module pvs_step #(
	parameter int K    = 0,
	parameter int FRAC = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pvs_pkg::pvs_beat_t up,
	output logic               up_ready,
	output pvs_pkg::pvs_beat_t dn,
	input  logic               dn_ready,
	input  pvs_pkg::pvs_coef_t coef
);

	localparam int W_HI = pvs_pkg::W_Q48 - pvs_pkg::MUL_SPLIT + pvs_pkg::W_POINT;
	localparam int W_LO = pvs_pkg::MUL_SPLIT + pvs_pkg::W_POINT + 1;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic signed [pvs_pkg::W_POINT-1:0] x_s1, x_s2, x_s3;
	logic vsat_s1, vsat_s2, vsat_s3;
	logic ssat_s1, ssat_s2, ssat_s3;

	logic signed [W_HI-1:0]                vhi_s1;
	logic signed [W_LO-1:0]                vlo_s1;
	logic signed [pvs_pkg::W_PROD-1:0]     vrnd_s2;
	logic signed [pvs_pkg::W_Q48-1:0]      val_s3;
	logic signed [pvs_pkg::W_Q48-1:0]      slp_s3;
	pvs_pkg::pvs_clip_t                    vacc;

	// Stall chain: a stage loads when it is empty or its successor loads.
	assign en_s3    = !v_s3 || dn_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	assign vacc = pvs_pkg::pvs_accumulate(vrnd_s2, $signed(coef.val_term[K]));

	// Value lane and shared fields.
	always_ff @(posedge clk) begin
		if (en_s1 && up.valid) begin
			vlo_s1  <= $signed({1'b0, up.data.val[pvs_pkg::MUL_SPLIT-1:0]}) * up.data.x;
			vhi_s1  <= $signed(up.data.val[pvs_pkg::W_Q48-1:pvs_pkg::MUL_SPLIT]) * up.data.x;
			x_s1    <= up.data.x;
			vsat_s1 <= up.data.vsat;
		end
		if (en_s2 && v_s1) begin
			vrnd_s2 <= pvs_pkg::pvs_round(vhi_s1, vlo_s1, FRAC);
			x_s2    <= x_s1;
			vsat_s2 <= vsat_s1;
		end
		if (en_s3 && v_s2) begin
			val_s3  <= vacc.val;
			vsat_s3 <= vsat_s2 | vacc.sat;
			x_s3    <= x_s2;
		end
	end

	if (K > 0) begin : g_slope
		// Slope lane: same multiply, round and accumulate with the k * coeff_k term.
		logic signed [W_HI-1:0]            shi_s1;
		logic signed [W_LO-1:0]            slo_s1;
		logic signed [pvs_pkg::W_PROD-1:0] srnd_s2;
		pvs_pkg::pvs_clip_t                sacc;

		assign sacc = pvs_pkg::pvs_accumulate(srnd_s2, $signed(coef.slp_term[K]));

		always_ff @(posedge clk) begin
			if (en_s1 && up.valid) begin
				slo_s1  <= $signed({1'b0, up.data.slp[pvs_pkg::MUL_SPLIT-1:0]}) * up.data.x;
				shi_s1  <= $signed(up.data.slp[pvs_pkg::W_Q48-1:pvs_pkg::MUL_SPLIT]) * up.data.x;
				ssat_s1 <= up.data.ssat;
			end
			if (en_s2 && v_s1) begin
				srnd_s2 <= pvs_pkg::pvs_round(shi_s1, slo_s1, FRAC);
				ssat_s2 <= ssat_s1;
			end
			if (en_s3 && v_s2) begin
				slp_s3  <= sacc.val;
				ssat_s3 <= ssat_s2 | sacc.sat;
			end
		end
	end else begin : g_slope_pass
		// The constant term has no slope contribution: the slope only keeps pace.
		logic signed [pvs_pkg::W_Q48-1:0] slp_s1, slp_s2;

		always_ff @(posedge clk) begin
			if (en_s1 && up.valid) begin
				slp_s1  <= up.data.slp;
				ssat_s1 <= up.data.ssat;
			end
			if (en_s2 && v_s1) begin
				slp_s2  <= slp_s1;
				ssat_s2 <= ssat_s1;
			end
			if (en_s3 && v_s2) begin
				slp_s3  <= slp_s2;
				ssat_s3 <= ssat_s2;
			end
		end
	end

	assign dn.valid     = v_s3;
	assign dn.data.val  = val_s3;
	assign dn.data.slp  = slp_s3;
	assign dn.data.vsat = vsat_s3;
	assign dn.data.ssat = ssat_s3;
	assign dn.data.x    = x_s3;

endmodule

[sv/polynomial_value_and_slope.sv]
`timescale 1ns / 1ps
// Top level of the polynomial value and slope block.
// Depends on pvs_pkg, the channel interfaces, pvs_cfg and pvs_step.

// Evaluates a calibration polynomial of up to MAX_TERMS coefficients and its first
// derivative at one Q16.16 point per cycle, both by Horner's rule in saturating Q16.32.
// A new point is taken every clock cycle while results are taken or a stage is empty.
// Each point passes the input register, three stages per Horner step (split 48 x 32
// multiply, round, add the next term with clipping) for MAX_TERMS - 1 steps, and the
// output register. Every stage holds its own valid bit, so bubbles close up under
// back-pressure and the input keeps accepting while results wait, as long as a stage
// is empty. Coefficient and term count writes are meant for idle periods only.
// A changed setting passes the register file, then the term register, to the pipeline.

module polynomial_value_and_slope #(
	parameter int MAX_TERMS       = 6,
	parameter int POINT_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pvs_point_if.sink     points,
	pvs_result_if.source  results,
	pvs_cfg_if.sink       cfg
);

	localparam int STEPS = MAX_TERMS - 1;

	pvs_pkg::pvs_coef_t coef;
	pvs_pkg::pvs_beat_t beat [STEPS+1];
	logic               rdy [STEPS+1];

	logic                               v_s0;
	logic                               en_s0;
	logic signed [pvs_pkg::W_POINT-1:0] x_s0;

	logic                               res_valid_q;
	logic                               en_out;
	logic signed [pvs_pkg::W_Q48-1:0]   value_q;
	logic signed [pvs_pkg::W_Q48-1:0]   slope_q;
	logic                               vsat_q;
	logic                               ssat_q;

	// Configuration registers.
	pvs_cfg #(
		.MAX_TERMS(MAX_TERMS)
	) u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.coef  (coef)
	);

	// Input register.
	assign en_s0        = !v_s0 || rdy[0];
	assign points.ready = en_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en_s0) begin
			v_s0 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s0 && points.valid) begin
			x_s0 <= points.point;
		end
	end

	// Horner seeds: the highest term in use; unused higher terms are zero.
	assign beat[0].valid     = v_s0;
	assign beat[0].data.val  = coef.val_term[MAX_TERMS-1];
	assign beat[0].data.slp  = coef.slp_term[MAX_TERMS-1];
	assign beat[0].data.vsat = 1'b0;
	assign beat[0].data.ssat = coef.slp_sat;
	assign beat[0].data.x    = x_s0;

	// Horner steps from the second-highest term down to the constant term.
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		pvs_step #(
			.K   (MAX_TERMS - 2 - j),
			.FRAC(POINT_FRAC_BITS)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.up      (beat[j]),
			.up_ready(rdy[j]),
			.dn      (beat[j+1]),
			.dn_ready(rdy[j+1]),
			.coef    (coef)
		);
	end

	// Output register.
	assign en_out     = !res_valid_q || results.ready;
	assign rdy[STEPS] = en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= beat[STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && beat[STEPS].valid) begin
			value_q <= beat[STEPS].data.val;
			slope_q <= beat[STEPS].data.slp;
			vsat_q  <= beat[STEPS].data.vsat;
			ssat_q  <= beat[STEPS].data.ssat;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.value           = value_q;
	assign results.slope           = slope_q;
	assign results.value_saturated = vsat_q;
	assign results.slope_saturated = ssat_q;

endmodule

[sv/pvs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the polynomial value and slope block, bound to its top level.
// Depends on pvs_pkg and polynomial_value_and_slope.

module pvs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [pvs_pkg::W_Q48-1:0] value,
	input logic signed [pvs_pkg::W_Q48-1:0] slope,
	input logic                             vsat,
	input logic                             ssat,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [pvs_pkg::W_REG_IDX-1:0]    cfg_index,
	input logic [pvs_pkg::W_Q48-1:0]        cfg_data
);

	logic [7:0]                  inflight_q;
	logic [pvs_pkg::W_TERMS-1:0] tc_q;

	// Count transactions taken but not yet delivered, and track the term count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			tc_q       <= pvs_pkg::TERM_COUNT_RESET;
		end else begin
			inflight_q <= 8'(inflight_q + 8'(in_valid && in_ready) - 8'(res_valid && res_ready));
			if (cfg_valid && cfg_ready && cfg_index == pvs_pkg::REG_TERM_COUNT) begin
				tc_q <= cfg_data[pvs_pkg::W_TERMS-1:0];
			end
		end
	end

	// A result held back keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value) && $stable(slope)
			&& $stable(vsat) && $stable(ssat))
		else $error("result changed while stalled");

	// With the output register empty the whole pipeline can advance.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> in_ready)
		else $error("input stalled with no result pending");

	// No result without a point taken for it.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 8'd0)
		else $error("result without a matching input transaction");

	// Zero terms give a zero value.
	a_no_terms: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && tc_q == 3'd0 |-> value == '0 && !vsat)
		else $error("value nonzero with no terms");

	// A constant polynomial has zero slope.
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (tc_q == 3'd0 || tc_q == 3'd1) |-> slope == '0 && !ssat)
		else $error("slope nonzero with at most one term");

endmodule

bind polynomial_value_and_slope pvs_checker u_pvs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (points.valid),
	.in_ready (points.ready),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.value    (results.value),
	.slope    (results.slope),
	.vsat     (results.value_saturated),
	.ssat     (results.slope_saturated),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.cfg_index(cfg.index),
	.cfg_data (cfg.data)
);
